/* rtl/signed_decimal_add_sub_mul_defines.svh */
// ----------------------------------------------------------------------------
// signed_decimal_add_sub_mul assertion macros
// shared property forms for the decimal arithmetic unit checks
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_ADD_SUB_MUL_DEFINES_SVH
`define SIGNED_DECIMAL_ADD_SUB_MUL_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SDASM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SDASM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sdasm_pkg.sv */
// ----------------------------------------------------------------------------
// sdasm_pkg
// shared constants, command/status types and digit helpers
// ----------------------------------------------------------------------------
`default_nettype none

package sdasm_pkg;

  localparam int NUM_DIGITS_DEF = 16;
  localparam int DIGIT_W        = 4;
  localparam int RADIX          = 10;
  localparam int DIGIT_MAX      = 9;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  typedef struct packed {
    logic store;      // write the accepted digit pair
    logic capture;    // latch operation and signs
    logic step;       // digit step, writes result store
    logic first;      // first step of a row, carry in is zero
    logic row0;       // first multiply row, partial sum is zero
    logic mul_addr;   // multiply addressing
    logic finish;     // latch sign and complement mode
    logic emit_load;  // load the output register
    logic emit_last;  // most significant digit
  } cmd_t;

  typedef struct packed {
    logic is_mul;
  } status_t;

  function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] m;
    m = DIGIT_W'(DIGIT_MAX);
    return (d > m) ? m : d;
  endfunction

  // quotient by ten of a value below 128, reciprocal multiply
  function automatic logic [3:0] div10(input logic [6:0] p);
    logic [14:0] t;
    t = {8'd0, p} * 15'd205;
    return t[14:11];
  endfunction

endpackage

`default_nettype wire

/* rtl/sdasm_ctrl.sv */
// ----------------------------------------------------------------------------
// sdasm_ctrl
// sequencer: operand load, digit steps, emission handshake
// ----------------------------------------------------------------------------
`default_nettype none

module sdasm_ctrl #(
  parameter int NUM_DIGITS = sdasm_pkg::NUM_DIGITS_DEF,
  localparam int IdxW = $clog2(NUM_DIGITS),
  localparam int CntW = $clog2(NUM_DIGITS + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire                   last_pair_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  input  sdasm_pkg::status_t    status_i,
  output sdasm_pkg::cmd_t       cmd_o,
  output logic [IdxW-1:0]       row_o,
  output logic [IdxW-1:0]       col_o,
  output logic [CntW-1:0]       fill_o
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_STEP,
    S_FINISH,
    S_EMIT_READ,
    S_EMIT_LOAD,
    S_EMIT_HOLD
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DIGITS - 1);
  localparam logic [IdxW:0]   LastSum = (IdxW+1)'(NUM_DIGITS - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(NUM_DIGITS);

  state_e          state_q;
  logic [IdxW-1:0] row_q;
  logic [IdxW-1:0] col_q;
  logic [CntW-1:0] fill_q;
  logic            out_valid_q;
  logic            in_acc;
  logic            row_end;

  assign in_acc  = in_valid_i && (state_q == S_LOAD);
  assign row_end = ({1'b0, row_q} + {1'b0, col_q}) == LastSum;

  always_comb begin
    cmd_o           = '0;
    cmd_o.store     = in_acc && (fill_q < FullCnt);
    cmd_o.capture   = in_acc && (fill_q == '0);
    cmd_o.step      = (state_q == S_STEP);
    cmd_o.first     = (col_q == '0);
    cmd_o.row0      = (row_q == '0);
    cmd_o.mul_addr  = status_i.is_mul && ((state_q == S_READ) || (state_q == S_STEP));
    cmd_o.finish    = (state_q == S_FINISH);
    cmd_o.emit_load = (state_q == S_EMIT_LOAD);
    cmd_o.emit_last = (col_q == LastIdx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      row_q       <= '0;
      col_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_valid_i) begin
            if (fill_q < FullCnt) begin
              fill_q <= fill_q + CntW'(1);
            end
            if (last_pair_i) begin
              row_q   <= '0;
              col_q   <= '0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (row_end) begin
            if (!status_i.is_mul || (row_q == LastIdx)) begin
              state_q <= S_FINISH;
            end else begin
              row_q   <= row_q + IdxW'(1);
              col_q   <= '0;
              state_q <= S_READ;
            end
          end else begin
            col_q   <= col_q + IdxW'(1);
            state_q <= S_READ;
          end
        end
        S_FINISH: begin
          col_q   <= '0;
          fill_q  <= '0;
          state_q <= S_EMIT_READ;
        end
        S_EMIT_READ: begin
          state_q <= S_EMIT_LOAD;
        end
        S_EMIT_LOAD: begin
          out_valid_q <= 1'b1;
          state_q     <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (col_q == LastIdx) begin
              state_q <= S_LOAD;
            end else begin
              col_q   <= col_q + IdxW'(1);
              state_q <= S_EMIT_READ;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign fill_o      = fill_q;

endmodule

`default_nettype wire

/* rtl/sdasm_datapath.sv */
// ----------------------------------------------------------------------------
// sdasm_datapath
// operand and result digit stores, digit alu, output register
// ----------------------------------------------------------------------------
`default_nettype none

module sdasm_datapath #(
  parameter int NUM_DIGITS = sdasm_pkg::NUM_DIGITS_DEF,
  localparam int IdxW = $clog2(NUM_DIGITS),
  localparam int CntW = $clog2(NUM_DIGITS + 1),
  localparam int DW   = sdasm_pkg::DIGIT_W
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  sdasm_pkg::cmd_t       cmd_i,
  output sdasm_pkg::status_t    status_o,
  input  wire [IdxW-1:0]        row_i,
  input  wire [IdxW-1:0]        col_i,
  input  wire [CntW-1:0]        fill_i,
  input  wire [1:0]             operation_i,
  input  wire [DW-1:0]          a_digit_i,
  input  wire [DW-1:0]          b_digit_i,
  input  wire                   a_negative_i,
  input  wire                   b_negative_i,
  output logic [DW-1:0]         result_digit_o,
  output logic                  result_negative_o,
  output logic                  result_last_o
);

  localparam logic [4:0] Radix5 = 5'(sdasm_pkg::RADIX);
  localparam logic [4:0] Max5   = 5'(sdasm_pkg::DIGIT_MAX);

  logic [DW-1:0] a_mem [NUM_DIGITS];
  logic [DW-1:0] b_mem [NUM_DIGITS];
  logic [DW-1:0] r_mem [NUM_DIGITS];

  logic [1:0]    op_q;
  logic          sa_q;
  logic          sb_q;
  logic [3:0]    carry_q;
  logic          neg_q;
  logic          cmpl_q;

  logic [DW-1:0] a_rd_q;
  logic [DW-1:0] b_rd_q;
  logic [DW-1:0] r_rd_q;
  logic          a_ok_q;
  logic          b_ok_q;
  logic [DW-1:0] dig_q;
  logic          last_q;

  logic [IdxW-1:0] a_addr;
  logic [IdxW-1:0] b_addr;
  logic [IdxW-1:0] r_addr;
  logic [IdxW:0]   mul_idx;
  logic [IdxW-1:0] wr_idx;

  logic          is_mul;
  logic          sb_eff;
  logic          sub_mode;

  logic [DW-1:0] a_v;
  logic [DW-1:0] b_v;
  logic [DW-1:0] r_v;
  logic [3:0]    c_in;
  logic [7:0]    prod;
  logic [6:0]    mul_sum;
  logic [3:0]    mul_q;
  logic [6:0]    mul_rem;
  logic [4:0]    add_sum;
  logic [4:0]    sub_need;
  logic          sub_bor;
  logic [4:0]    sub_diff;
  logic [DW-1:0] step_dig;
  logic [3:0]    step_carry;

  logic [4:0]    em_t;
  logic [4:0]    em_neg;
  logic [DW-1:0] em_dig;
  logic          em_bor;

  assign is_mul   = (op_q == sdasm_pkg::OP_MUL);
  assign sb_eff   = sb_q ^ (op_q == sdasm_pkg::OP_SUB);
  assign sub_mode = (sa_q != sb_eff);
  assign status_o.is_mul = is_mul;

  // partial products land at row + col
  assign mul_idx = {1'b0, row_i} + {1'b0, col_i};
  assign a_addr  = col_i;
  assign b_addr  = cmd_i.mul_addr ? row_i : col_i;
  assign r_addr  = cmd_i.mul_addr ? mul_idx[IdxW-1:0] : col_i;
  assign wr_idx  = fill_i[IdxW-1:0];

  always_comb begin
    a_v  = a_ok_q ? a_rd_q : '0;
    b_v  = b_ok_q ? b_rd_q : '0;
    r_v  = cmd_i.row0 ? '0 : r_rd_q;
    c_in = cmd_i.first ? '0 : carry_q;

    prod    = {4'd0, a_v} * {4'd0, b_v};
    mul_sum = 7'(r_v) + prod[6:0] + 7'(c_in);
    mul_q   = sdasm_pkg::div10(mul_sum);
    mul_rem = mul_sum - 7'(mul_q) * 7'(sdasm_pkg::RADIX);

    add_sum  = 5'(a_v) + 5'(b_v) + 5'(c_in[0]);
    sub_need = 5'(b_v) + 5'(c_in[0]);
    sub_bor  = 5'(a_v) < sub_need;
    sub_diff = sub_bor ? (5'(a_v) + Radix5 - sub_need) : (5'(a_v) - sub_need);

    if (is_mul) begin
      step_dig   = mul_rem[DW-1:0];
      step_carry = mul_q;
    end else if (sub_mode) begin
      step_dig   = sub_diff[DW-1:0];
      step_carry = {3'd0, sub_bor};
    end else if (add_sum > Max5) begin
      step_dig   = 4'(add_sum - Radix5);
      step_carry = 4'd1;
    end else begin
      step_dig   = add_sum[DW-1:0];
      step_carry = 4'd0;
    end

    // ten's complement on the way out when a - b borrowed
    em_t   = 5'(r_rd_q) + 5'(carry_q[0]);
    em_neg = Radix5 - em_t;
    if (!cmpl_q) begin
      em_dig = r_rd_q;
      em_bor = 1'b0;
    end else if (em_t == '0) begin
      em_dig = '0;
      em_bor = 1'b0;
    end else begin
      em_dig = em_neg[DW-1:0];
      em_bor = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= sdasm_pkg::OP_ADD;
      sa_q    <= 1'b0;
      sb_q    <= 1'b0;
      carry_q <= '0;
      neg_q   <= 1'b0;
      cmpl_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        op_q <= operation_i;
        sa_q <= a_negative_i;
        sb_q <= b_negative_i;
      end
      if (cmd_i.step) begin
        carry_q <= step_carry;
      end else if (cmd_i.finish) begin
        carry_q <= '0;
        cmpl_q  <= !is_mul && sub_mode && carry_q[0];
        if (is_mul) begin
          neg_q <= sa_q ^ sb_q;
        end else if (sub_mode && carry_q[0]) begin
          neg_q <= sb_eff;
        end else begin
          neg_q <= sa_q;
        end
      end else if (cmd_i.emit_load) begin
        carry_q <= {3'd0, em_bor};
      end
    end
  end

  // digit stores, registered reads; operand slots past the fill count read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      a_mem[wr_idx] <= sdasm_pkg::sat_digit(a_digit_i);
      b_mem[wr_idx] <= sdasm_pkg::sat_digit(b_digit_i);
    end
    if (cmd_i.step) begin
      r_mem[r_addr] <= step_dig;
    end
    a_rd_q <= a_mem[a_addr];
    b_rd_q <= b_mem[b_addr];
    r_rd_q <= r_mem[r_addr];
    a_ok_q <= CntW'(a_addr) < fill_i;
    b_ok_q <= CntW'(b_addr) < fill_i;
    if (cmd_i.emit_load) begin
      dig_q  <= em_dig;
      last_q <= cmd_i.emit_last;
    end
  end

  assign result_digit_o    = dig_q;
  assign result_negative_o = neg_q;
  assign result_last_o     = last_q;

endmodule

`default_nettype wire

/* rtl/signed_decimal_add_sub_mul.sv */
// ----------------------------------------------------------------------------
// signed_decimal_add_sub_mul
// signed-magnitude decimal add / subtract / multiply on NUM_DIGITS digits
// ----------------------------------------------------------------------------
//  channel | signals                                  | beat
//  --------+------------------------------------------+---------------------------
//  in      | in_valid_i / in_stall_o, operands, last  | one digit pair, lsd first
//  out     | out_valid_o / out_stall_i, result fields | one result digit, lsd first
//
//  load: one cycle per pair; the pair with last_pair_i starts the operation
//  add/sub: a store read and a digit step per digit, then a finish state
//  mul: a store read and a step per digit product (triangle), then a finish state
//  emit: read, load, hold per digit + out stall; input stalls until last digit
//  async reset clears control only, stores need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_decimal_add_sub_mul_defines.svh"

module signed_decimal_add_sub_mul #(
  parameter int NUM_DIGITS = sdasm_pkg::NUM_DIGITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [1:0]  operation_i,
  input  wire [3:0]  a_digit_i,
  input  wire [3:0]  b_digit_i,
  input  wire        a_negative_i,
  input  wire        b_negative_i,
  input  wire        last_pair_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [3:0] result_digit_o,
  output logic       result_negative_o,
  output logic       result_last_o
);

  localparam int IdxW = $clog2(NUM_DIGITS);
  localparam int CntW = $clog2(NUM_DIGITS + 1);

  sdasm_pkg::cmd_t    cmd;
  sdasm_pkg::status_t status;
  logic [IdxW-1:0]    row;
  logic [IdxW-1:0]    col;
  logic [CntW-1:0]    fill;

  sdasm_ctrl #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_pair_i (last_pair_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .row_o       (row),
    .col_o       (col),
    .fill_o      (fill)
  );

  sdasm_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .row_i             (row),
    .col_i             (col),
    .fill_i            (fill),
    .operation_i       (operation_i),
    .a_digit_i         (a_digit_i),
    .b_digit_i         (b_digit_i),
    .a_negative_i      (a_negative_i),
    .b_negative_i      (b_negative_i),
    .result_digit_o    (result_digit_o),
    .result_negative_o (result_negative_o),
    .result_last_o     (result_last_o)
  );

  `SDASM_ASSERT_NOW(a_no_load_while_emit, in_valid_i && !in_stall_o, !out_valid_o, "pair accepted while a result beat is pending")
  `SDASM_ASSERT_NEXT(a_last_pair_stalls, in_valid_i && !in_stall_o && last_pair_i, in_stall_o, "input not stalled after last pair")
  `SDASM_ASSERT_NEXT(a_ready_after_last, out_valid_o && !out_stall_i && result_last_o, !in_stall_o && !out_valid_o, "block not idle after last result beat")
  `SDASM_ASSERT_NEXT(a_sign_steady, out_valid_o && !out_stall_i && !result_last_o, result_negative_o == $past(result_negative_o), "result sign changed within an operation")
  `SDASM_ASSERT_NOW(a_digit_decimal, out_valid_o, result_digit_o <= 4'd9, "result digit is not decimal")

endmodule

`default_nettype wire

/* verif/signed_decimal_add_sub_mul_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_add_sub_mul_tb
// drives digit-pair operands into the decimal add / subtract / multiply unit
// and checks every result digit, sign and end marker against an in-bench
// signed-magnitude model, with random idling on both channels
// ----------------------------------------------------------------------------
module signed_decimal_add_sub_mul_tb;

  localparam int         DIGITS      = sdasm_pkg::NUM_DIGITS_DEF;
  localparam int         MAX_PAIRS   = DIGITS + 4;
  localparam logic [1:0] OP_SPARE    = 2'd3;  // unused code, the unit adds
  localparam int         TAIL_CYCLES = 60;
  localparam int         PRINT_LIMIT = 50;

  typedef struct packed {
    logic [3:0] digit;
    logic       neg;
    logic       msd;
  } result_beat_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [1:0] operation_i  = sdasm_pkg::OP_ADD;
  logic [3:0] a_digit_i    = 4'd0;
  logic [3:0] b_digit_i    = 4'd0;
  logic       a_negative_i = 1'b0;
  logic       b_negative_i = 1'b0;
  logic       last_pair_i  = 1'b0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [3:0] result_digit_o;
  logic       result_negative_o;
  logic       result_last_o;

  always #5 clk_i = ~clk_i;

  signed_decimal_add_sub_mul #(
    .NUM_DIGITS(DIGITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .a_digit_i        (a_digit_i),
    .b_digit_i        (b_digit_i),
    .a_negative_i     (a_negative_i),
    .b_negative_i     (b_negative_i),
    .last_pair_i      (last_pair_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_digit_o   (result_digit_o),
    .result_negative_o(result_negative_o),
    .result_last_o    (result_last_o)
  );

  // decimal unit model state
  logic [3:0] mag_a [DIGITS];
  logic [3:0] mag_b [DIGITS];
  logic [3:0] mag_r [DIGITS];
  int         pairs_held;
  logic [1:0] held_op;
  logic       held_a_neg;
  logic       held_b_neg;

  result_beat_t pending_digits[$];

  int err_count      = 0;
  int pairs_sent     = 0;
  int digits_checked = 0;
  int ops_done[4]    = '{0, 0, 0, 0};
  bit idle_on        = 1'b1;

  // operand digits staged for the sender
  logic [3:0] stage_a [MAX_PAIRS];
  logic [3:0] stage_b [MAX_PAIRS];

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_LIMIT) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  function automatic void clear_operands();
    for (int i = 0; i < DIGITS; i++) begin
      mag_a[i] = 4'd0;
      mag_b[i] = 4'd0;
    end
    pairs_held = 0;
  endfunction

  function automatic bit a_below_b();
    for (int i = DIGITS - 1; i >= 0; i--) begin
      if (mag_a[i] != mag_b[i]) return mag_a[i] < mag_b[i];
    end
    return 1'b0;
  endfunction

  function automatic void decimal_add();
    int s;
    int carry;
    carry = 0;
    for (int i = 0; i < DIGITS; i++) begin
      s        = int'(mag_a[i]) + int'(mag_b[i]) + carry;
      mag_r[i] = 4'(s % 10);
      carry    = (s > 9) ? 1 : 0;
    end
  endfunction

  // larger minus smaller; swap picks b as the larger
  function automatic void decimal_subtract(input bit swap);
    int borrow;
    int xd;
    int need;
    borrow = 0;
    for (int i = 0; i < DIGITS; i++) begin
      xd   = swap ? int'(mag_b[i]) : int'(mag_a[i]);
      need = (swap ? int'(mag_a[i]) : int'(mag_b[i])) + borrow;
      if (xd < need) begin
        mag_r[i] = 4'(xd + 10 - need);
        borrow   = 1;
      end else begin
        mag_r[i] = 4'(xd - need);
        borrow   = 0;
      end
    end
  endfunction

  // schoolbook product, digits at or above DIGITS dropped
  function automatic void decimal_multiply();
    int p;
    int carry;
    for (int i = 0; i < DIGITS; i++) mag_r[i] = 4'd0;
    for (int i = 0; i < DIGITS; i++) begin
      carry = 0;
      for (int n = 0; i + n < DIGITS; n++) begin
        p            = int'(mag_r[i + n]) + int'(mag_a[n]) * int'(mag_b[i]) + carry;
        mag_r[i + n] = 4'(p % 10);
        carry        = p / 10;
      end
    end
  endfunction

  function automatic void absorb_pair(input logic [1:0] op, input logic [3:0] ad,
                                      input logic [3:0] bd, input logic an,
                                      input logic bn, input logic fin);
    logic sa;
    logic sb;
    logic rneg;
    if (pairs_held == 0) begin
      held_op    = op;
      held_a_neg = an;
      held_b_neg = bn;
    end
    if (pairs_held < DIGITS) begin
      mag_a[pairs_held] = (ad > 4'd9) ? 4'd9 : ad;
      mag_b[pairs_held] = (bd > 4'd9) ? 4'd9 : bd;
      pairs_held++;
    end
    if (fin) begin
      sa = held_a_neg;
      sb = held_b_neg;
      if (held_op == sdasm_pkg::OP_MUL) begin
        rneg = sa ^ sb;
        decimal_multiply();
      end else begin
        if (held_op == sdasm_pkg::OP_SUB) sb = ~sb;
        if (sa == sb) begin
          rneg = sa;
          decimal_add();
        end else if (a_below_b()) begin
          rneg = sb;
          decimal_subtract(1'b1);
        end else begin
          rneg = sa;
          decimal_subtract(1'b0);
        end
      end
      for (int k = 0; k < DIGITS; k++) begin
        pending_digits.push_back('{mag_r[k], rneg, (k == DIGITS - 1)});
      end
      ops_done[held_op]++;
      clear_operands();
    end
  endfunction

  // one beat on the input channel; valid stays high after acceptance
  task automatic send_pair(input logic [1:0] op, input logic [3:0] ad, input logic [3:0] bd,
                           input logic an, input logic bn, input logic fin);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    a_digit_i    <= ad;
    b_digit_i    <= bd;
    a_negative_i <= an;
    b_negative_i <= bn;
    last_pair_i  <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_pair(op, ad, bd, an, bn, fin);
    pairs_sent++;
  endtask

  // operation and signs only count on the opening pair, so later ones carry noise
  task automatic send_operation(input logic [1:0] op, input logic an, input logic bn,
                                input int n);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        send_pair(op, stage_a[0], stage_b[0], an, bn, n == 1);
      end else begin
        send_pair(2'($urandom_range(0, 3)), stage_a[i], stage_b[i],
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), i == n - 1);
      end
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_digits.size() != 0);
  endtask

  function automatic logic [3:0] rand_digit();
    if ($urandom_range(0, 11) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  function automatic void stage_random(input int n);
    int shape;
    shape = $urandom_range(0, 7);
    for (int i = 0; i < n; i++) begin
      stage_a[i] = (shape == 0) ? 4'd9 : (shape == 1) ? 4'd0 : rand_digit();
      stage_b[i] = (shape == 2) ? stage_a[i] : (shape == 3) ? 4'd9 : rand_digit();
    end
  endfunction

  // mostly short operands, some full width, a few running past the store
  function automatic int draw_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 4);
    if (r < 17) return $urandom_range(5, DIGITS - 1);
    if (r < 19) return DIGITS;
    return $urandom_range(DIGITS + 1, MAX_PAIRS);
  endfunction

  function automatic logic [1:0] draw_op();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return sdasm_pkg::OP_ADD;
    if (r < 6) return sdasm_pkg::OP_SUB;
    if (r < 9) return sdasm_pkg::OP_MUL;
    return OP_SPARE;
  endfunction

  task automatic random_operation();
    int n;
    n = draw_length();
    stage_random(n);
    send_operation(draw_op(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), n);
  endtask

  task automatic test_directed_cases();
    idle_on = 1'b1;
    // overlong multiply: a digits saturate to nine, closing pair lands past the store
    for (int i = 0; i < MAX_PAIRS; i++) begin
      stage_a[i] = 4'd15;
      stage_b[i] = 4'd9;
    end
    send_operation(sdasm_pkg::OP_MUL, 1'b0, 1'b0, DIGITS + 1);
    // two negative zeros added give negative zero
    stage_a[0] = 4'd0;
    stage_b[0] = 4'd0;
    send_operation(sdasm_pkg::OP_ADD, 1'b1, 1'b1, 1);
    // equal magnitudes keep a's sign
    stage_a[0] = 4'd5;
    stage_b[0] = 4'd5;
    send_operation(sdasm_pkg::OP_SUB, 1'b1, 1'b1, 1);
    // b larger on subtract, sign follows inverted b
    stage_a[0] = 4'd3;
    stage_a[1] = 4'd1;
    stage_b[0] = 4'd7;
    stage_b[1] = 4'd4;
    send_operation(sdasm_pkg::OP_SUB, 1'b0, 1'b0, 2);
    // spare operation code adds, with a carry
    stage_a[0] = 4'd9;
    stage_b[0] = 4'd9;
    send_operation(OP_SPARE, 1'b0, 1'b0, 1);
    // product sign is the xor, b digit above nine saturates
    stage_a[0] = 4'd7;
    stage_b[0] = 4'd12;
    send_operation(sdasm_pkg::OP_MUL, 1'b1, 1'b0, 1);
    // mixed signs on add, b larger
    stage_a[0] = 4'd2;
    stage_b[0] = 4'd9;
    send_operation(sdasm_pkg::OP_ADD, 1'b0, 1'b1, 1);
    // a larger on subtract
    stage_a[0] = 4'd8;
    stage_b[0] = 4'd3;
    send_operation(sdasm_pkg::OP_SUB, 1'b0, 1'b0, 1);
  endtask

  task automatic test_random_traffic(input int pair_budget);
    int start;
    idle_on = 1'b1;
    start   = pairs_sent;
    while (pairs_sent - start < pair_budget) random_operation();
  endtask

  task automatic test_back_to_back(input int pair_budget);
    int start;
    idle_on = 1'b0;
    start   = pairs_sent;
    while (pairs_sent - start < pair_budget) random_operation();
    idle_on = 1'b1;
  endtask

  task automatic test_pause_until_drained(input int n_ops);
    idle_on = 1'b1;
    repeat (n_ops) begin
      random_operation();
      wait_results_drained();
    end
  endtask

  initial begin : result_checker
    int           hold;
    result_beat_t want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_digits.size() == 0) begin
          report_mismatch($sformatf("result digit %0d with nothing pending", result_digit_o));
        end else begin
          want = pending_digits.pop_front();
          if (result_digit_o !== want.digit) begin
            report_mismatch($sformatf("result_digit %0d, want %0d", result_digit_o, want.digit));
          end
          if (result_negative_o !== want.neg) begin
            report_mismatch($sformatf("result_negative %b, want %b", result_negative_o,
                                      want.neg));
          end
          if (result_last_o !== want.msd) begin
            report_mismatch($sformatf("result_last %b, want %b", result_last_o, want.msd));
          end
          digits_checked++;
        end
        hold = idle_on ? $urandom_range(0, 11) : 0;
      end else if (out_valid_o && hold > 0) begin
        // stall cycles only count while a beat is offered
        hold--;
      end
      out_stall_i <= (hold > 0);
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d result digits outstanding", pending_digits.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    clear_operands();
    held_op    = sdasm_pkg::OP_ADD;
    held_a_neg = 1'b0;
    held_b_neg = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(150);
    wait_results_drained();
    test_back_to_back(100);
    wait_results_drained();
    test_pause_until_drained(15);
    test_random_traffic(40);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d digit pairs: %0d add, %0d subtract, %0d multiply, %0d spare-code operations",
             pairs_sent, ops_done[sdasm_pkg::OP_ADD], ops_done[sdasm_pkg::OP_SUB],
             ops_done[sdasm_pkg::OP_MUL], ops_done[OP_SPARE]);
    $display("%0d result digits checked, %0d mismatches", digits_checked, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
